[src/prs_pkg.sv]
// ----------------------------------------------------------------------------
// prs_pkg: shared types and constants of the packet resequencer
// Holds the field widths, the slot entry layout, the controller states and
// the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package prs_pkg;

  // Default number of slots in the receive window.
  localparam int unsigned WINDOW_DEF = 32;

  // Largest payload length that is accepted; longer packets are malformed.
  localparam logic [15:0] MAX_PAYLOAD = 16'd1024;

  // Field widths.
  localparam int unsigned SEQ_W   = 32;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned FIELD_W = SEQ_W + TAG_W + LEN_W;
  localparam int unsigned TDATA_W = ((FIELD_W + 7) / 8) * 8;
  localparam int unsigned PAD_W   = TDATA_W - FIELD_W;

  // Result kinds.
  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  // One window slot.
  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [LEN_W-1:0] len;
  } entry_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_STORE,
    ST_HEAD_RD,
    ST_WALK,
    ST_NEXT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_load;   // capture the accepted input word
    logic clr_en;    // clear one slot of the window memory
    logic ack_load;  // load an ack into the output register
    logic rd_slot;   // read the slot that the packet maps to
    logic st_en;     // store the packet if its slot is empty
    logic adv;       // take the head slot, free it and step the head
    logic dlv_load;  // load the held delivery into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;  // the clearing pass is at its last slot
    logic drop;      // packet is dropped without any result
    logic in_win;    // packet lies inside the receive window
    logic d_zero;    // packet carries the expected sequence number
    logic out_free;  // output register can take a word this cycle
    logic rd_valid;  // slot read last cycle holds a packet
  } sts_t;

endpackage

[src/packet_resequencer_core.sv]
// ----------------------------------------------------------------------------
// packet_resequencer_core: receive side of a selective-repeat transport
// Acks good packets, holds them in a window of slots and delivers them in
// sequence order.
// ----------------------------------------------------------------------------
// After reset the block clears its WINDOW slots, one per cycle, and takes no
// word until that pass is done. A packet with a bad CRC or an oversize length,
// or one more than WINDOW-1 ahead of the expected number, is dropped with no
// result. Any other packet gives an ack first, once the output register is
// free; an old packet is done after that, a packet inside the window is
// stored, and a packet carrying the expected number then starts an in-order
// walk that delivers each held slot in turn. The walk reads one slot per
// cycle through the registered read port of the slot memory, while the output
// register can take a word. A finished word waits in an output register, so
// the next packet can be taken while it is still pending.
// ----------------------------------------------------------------------------
module packet_resequencer_core #(
  parameter int unsigned WINDOW = prs_pkg::WINDOW_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input packet words.
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [prs_pkg::TDATA_W-1:0] s_axis_tdata_i,  // seq, payload_tag, payload_len
  input  logic                        s_axis_tuser_i,  // crc_ok
  // Result words.
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [prs_pkg::TDATA_W-1:0] m_axis_tdata_o,  // out_seq, out_tag, out_len
  output logic                        m_axis_tuser_o,  // kind
  output logic                        m_axis_tlast_o   // last
);

  prs_pkg::cmd_t cmd;
  prs_pkg::sts_t sts;

  // Sequencing of each packet.
  prs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Window storage and result formatting.
  prs_dpath #(
    .WINDOW (WINDOW)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

[src/prs_ctrl.sv]
// ----------------------------------------------------------------------------
// prs_ctrl: controller of the packet resequencer
// Sequences the clearing pass, the classification and storing of a packet,
// and the in-order walk over the window slots.
// ----------------------------------------------------------------------------
module prs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  prs_pkg::sts_t sts_i,
  output prs_pkg::cmd_t cmd_o
);

  prs_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prs_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      prs_pkg::ST_CLEAR: begin
        if (sts_i.clr_done) state_d = prs_pkg::ST_IDLE;
      end
      prs_pkg::ST_IDLE: begin
        if (s_valid_i) state_d = prs_pkg::ST_CHECK;
      end
      prs_pkg::ST_CHECK: begin
        if (sts_i.drop) begin
          state_d = prs_pkg::ST_IDLE;
        end else if (sts_i.out_free) begin
          state_d = sts_i.in_win ? prs_pkg::ST_STORE : prs_pkg::ST_IDLE;
        end
      end
      prs_pkg::ST_STORE: begin
        state_d = sts_i.d_zero ? prs_pkg::ST_HEAD_RD : prs_pkg::ST_IDLE;
      end
      prs_pkg::ST_HEAD_RD: begin
        state_d = prs_pkg::ST_WALK;
      end
      prs_pkg::ST_WALK: begin
        state_d = prs_pkg::ST_NEXT;
      end
      prs_pkg::ST_NEXT: begin
        if (sts_i.out_free && !sts_i.rd_valid) state_d = prs_pkg::ST_IDLE;
      end
      default: state_d = prs_pkg::ST_CLEAR;
    endcase
  end

  // Output logic.
  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      prs_pkg::ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
      end
      prs_pkg::ST_IDLE: begin
        s_ready_o     = 1'b1;
        cmd_o.in_load = s_valid_i;
      end
      prs_pkg::ST_CHECK: begin
        if (!sts_i.drop && sts_i.out_free) begin
          cmd_o.ack_load = 1'b1;
          cmd_o.rd_slot  = 1'b1;
        end
      end
      prs_pkg::ST_STORE: begin
        cmd_o.st_en = 1'b1;
      end
      prs_pkg::ST_HEAD_RD: begin
        cmd_o = '0;
      end
      prs_pkg::ST_WALK: begin
        cmd_o.adv = 1'b1;
      end
      prs_pkg::ST_NEXT: begin
        if (sts_i.out_free) begin
          cmd_o.dlv_load = 1'b1;
          cmd_o.adv      = sts_i.rd_valid;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

[src/prs_dpath.sv]
// ----------------------------------------------------------------------------
// prs_dpath: datapath of the packet resequencer
// Holds the input word, the expected sequence number, the window head, the
// slot memory, the delivery being walked and the output register.
// ----------------------------------------------------------------------------
module prs_dpath #(
  parameter int unsigned WINDOW = prs_pkg::WINDOW_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [prs_pkg::TDATA_W-1:0] s_tdata_i,
  input  logic                        s_tuser_i,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [prs_pkg::TDATA_W-1:0] m_tdata_o,
  output logic                        m_tuser_o,
  output logic                        m_tlast_o,
  input  prs_pkg::cmd_t               cmd_i,
  output prs_pkg::sts_t               sts_o
);

  localparam int unsigned IW = $clog2(WINDOW);
  localparam int unsigned SW = prs_pkg::SEQ_W;
  localparam int unsigned TW = prs_pkg::TAG_W;
  localparam int unsigned LW = prs_pkg::LEN_W;

  // Captured input word.
  logic [SW-1:0] seq_q;
  logic [TW-1:0] tag_q;
  logic [LW-1:0] len_q;
  logic          ok_q;
  logic [SW-1:0] dist_q;

  // Window state.
  logic [SW-1:0] exp_q;
  logic [IW-1:0] head_q;
  logic [IW-1:0] clr_q;

  // Delivery held until the next slot has been looked at.
  prs_pkg::entry_t cur_q;
  logic [SW-1:0]   cur_seq_q;

  // Slot memory and its read and write ports.
  prs_pkg::entry_t slot_mem_q [WINDOW];
  prs_pkg::entry_t rdata_q;
  prs_pkg::entry_t wdata;
  logic [IW-1:0]   waddr;
  logic [IW-1:0]   raddr;
  logic            we;

  // Output register.
  logic          out_valid_q;
  logic          out_kind_q;
  logic [SW-1:0] out_seq_q;
  logic [TW-1:0] out_tag_q;
  logic [LW-1:0] out_len_q;
  logic          out_last_q;

  // Packet classification and slot arithmetic.
  logic          in_win;
  logic          old_pkt;
  logic          bad_pkt;
  logic          d_zero;
  logic          ack_last;
  logic          out_free;
  logic [IW:0]   slot_sum;
  logic [IW-1:0] slot;
  logic [IW-1:0] head_inc;

  always_comb begin
    in_win   = dist_q < SW'(WINDOW);
    old_pkt  = dist_q[SW-1];
    bad_pkt  = !ok_q || (16'(len_q) > prs_pkg::MAX_PAYLOAD);
    d_zero   = dist_q == '0;
    ack_last = !(in_win && d_zero);
    out_free = !out_valid_q || m_tready_i;
    slot_sum = {1'b0, head_q} + {1'b0, dist_q[IW-1:0]};
    if (slot_sum >= (IW+1)'(WINDOW)) begin
      slot = IW'(slot_sum - (IW+1)'(WINDOW));
    end else begin
      slot = slot_sum[IW-1:0];
    end
    if (head_q == IW'(WINDOW - 1)) begin
      head_inc = '0;
    end else begin
      head_inc = head_q + IW'(1);
    end
  end

  // Status to the controller.
  always_comb begin
    sts_o.clr_done = clr_q == IW'(WINDOW - 1);
    sts_o.drop     = bad_pkt || (!in_win && !old_pkt);
    sts_o.in_win   = in_win;
    sts_o.d_zero   = d_zero;
    sts_o.out_free = out_free;
    sts_o.rd_valid = rdata_q.valid;
  end

  // Input word capture; the distance is taken against the expected number.
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      seq_q  <= s_tdata_i[SW-1:0];
      tag_q  <= s_tdata_i[SW+TW-1:SW];
      len_q  <= s_tdata_i[SW+TW+LW-1:SW+TW];
      ok_q   <= s_tuser_i;
      dist_q <= s_tdata_i[SW-1:0] - exp_q;
    end
  end

  // Expected sequence number, head index and clearing counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q  <= SW'(1);
      head_q <= '0;
      clr_q  <= '0;
    end else begin
      if (cmd_i.adv) begin
        exp_q  <= exp_q + SW'(1);
        head_q <= head_inc;
      end
      if (cmd_i.clr_en) begin
        clr_q <= clr_q + IW'(1);
      end
    end
  end

  // The held delivery takes the head slot as the head moves on.
  always_ff @(posedge clk_i) begin
    if (cmd_i.adv) begin
      cur_q     <= rdata_q;
      cur_seq_q <= exp_q;
    end
  end

  // Memory port selection; a held slot keeps its first contents.
  always_comb begin
    wdata = '0;
    if (cmd_i.clr_en) begin
      waddr = clr_q;
    end else if (cmd_i.st_en) begin
      waddr = slot;
      wdata = '{valid: 1'b1, tag: tag_q, len: len_q};
    end else begin
      waddr = head_q;
    end
    we = cmd_i.clr_en || (cmd_i.st_en && !rdata_q.valid) || cmd_i.adv;
    if (cmd_i.rd_slot) begin
      raddr = slot;
    end else if (cmd_i.adv) begin
      raddr = head_inc;
    end else begin
      raddr = head_q;
    end
  end

  // Slot memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (we) begin
      slot_mem_q[waddr] <= wdata;
    end
    rdata_q <= slot_mem_q[raddr];
  end

  // Output register: valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.ack_load || cmd_i.dlv_load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register: payload of an ack or a delivery.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ack_load) begin
      out_kind_q <= prs_pkg::KIND_ACK;
      out_seq_q  <= seq_q;
      out_tag_q  <= '0;
      out_len_q  <= '0;
      out_last_q <= ack_last;
    end else if (cmd_i.dlv_load) begin
      out_kind_q <= prs_pkg::KIND_DELIVER;
      out_seq_q  <= cur_seq_q;
      out_tag_q  <= cur_q.tag;
      out_len_q  <= cur_q.len;
      out_last_q <= !rdata_q.valid;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {{prs_pkg::PAD_W{1'b0}}, out_len_q, out_tag_q, out_seq_q};
  assign m_tuser_o  = out_kind_q;
  assign m_tlast_o  = out_last_q;

endmodule

[sim/prs_checker.sv]
// ----------------------------------------------------------------------------
// prs_checker: result checker for the packet resequencer
// Watches both stream channels of the block. Every packet word taken by the
// block runs through a local copy of the receive window, which works out the
// ack and the in-order deliveries that the packet owes. Every result word
// leaving the block is compared field by field with the oldest owed word.
// ----------------------------------------------------------------------------
module prs_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Packet channel, as seen at the block's slave side.
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [prs_pkg::TDATA_W-1:0] in_data_i,   // seq, payload_tag, payload_len
  input  logic                        in_user_i,   // crc_ok
  // Result channel, as seen at the block's master side.
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [prs_pkg::TDATA_W-1:0] out_data_i,  // out_seq, out_tag, out_len
  input  logic                        out_user_i,  // kind
  input  logic                        out_last_i,  // last
  // Status toward the test top.
  output int                          errors_o,
  output int                          pending_o
);

  localparam int unsigned SLOTS  = prs_pkg::WINDOW_DEF;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned SEQ_W  = prs_pkg::SEQ_W;
  localparam int unsigned TAG_W  = prs_pkg::TAG_W;
  localparam int unsigned LEN_W  = prs_pkg::LEN_W;

  // One result word that the block still owes.
  typedef struct packed {
    logic             kind;
    logic [SEQ_W-1:0] seq;
    logic [TAG_W-1:0] tag;
    logic [LEN_W-1:0] len;
    logic             last;
  } result_t;

  // Local copy of the receive window.
  logic [SEQ_W-1:0]  next_seq;
  logic              held     [SLOTS];
  logic [TAG_W-1:0]  held_tag [SLOTS];
  logic [LEN_W-1:0]  held_len [SLOTS];
  logic [SLOT_W-1:0] head_slot;

  result_t owed_words[$];
  int      err_count;

  // Prints one mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [SEQ_W-1:0] got,
                                 input logic [SEQ_W-1:0] want);
    $display("[%0t] prs_checker: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  // Runs one accepted packet through the window and queues the words it owes:
  // the ack first, then every delivery that the packet releases.
  task automatic resequence_packet(input logic [SEQ_W-1:0] seq,
                                   input logic [TAG_W-1:0] tag,
                                   input logic [LEN_W-1:0] len,
                                   input logic crc_ok);
    logic [SEQ_W-1:0]  seq_gap;
    logic [SLOT_W-1:0] slot;
    result_t           word;
    // Bad CRC and oversize lengths are dropped without a trace.
    if (!crc_ok || {5'd0, len} > prs_pkg::MAX_PAYLOAD) begin
      return;
    end
    seq_gap = seq - next_seq;
    // Packets ahead of the window are dropped unacked.
    if (seq_gap >= SLOTS && seq_gap < 32'h8000_0000) begin
      return;
    end
    word = '{kind: prs_pkg::KIND_ACK, seq: seq, tag: '0, len: '0, last: 1'b0};
    if (seq_gap < SLOTS) begin
      // A held slot keeps its first contents; a duplicate is only acked.
      slot = head_slot + seq_gap[SLOT_W-1:0];
      if (!held[slot]) begin
        held[slot]     = 1'b1;
        held_tag[slot] = tag;
        held_len[slot] = len;
      end
      // Release everything that is now contiguous from the head.
      while (held[head_slot]) begin
        owed_words.push_back(word);
        word = '{kind: prs_pkg::KIND_DELIVER, seq: next_seq, tag: held_tag[head_slot],
                 len: held_len[head_slot], last: 1'b0};
        held[head_slot] = 1'b0;
        next_seq        = next_seq + 1'b1;
        head_slot       = head_slot + 1'b1;
      end
    end
    word.last = 1'b1;
    owed_words.push_back(word);
  endtask

  // Compares one result word with the oldest owed word.
  task automatic check_word(input logic [prs_pkg::TDATA_W-1:0] data, input logic kind,
                            input logic last);
    result_t want;
    if (owed_words.size() == 0) begin
      report_mismatch("result word with nothing owed, seq", data[SEQ_W-1:0], '0);
      return;
    end
    want = owed_words.pop_front();
    if (kind !== want.kind) begin
      report_mismatch("kind", 32'(kind), 32'(want.kind));
    end
    if (data[SEQ_W-1:0] !== want.seq) begin
      report_mismatch("out_seq", data[SEQ_W-1:0], want.seq);
    end
    if (data[SEQ_W+:TAG_W] !== want.tag) begin
      report_mismatch("out_tag", 32'(data[SEQ_W+:TAG_W]), 32'(want.tag));
    end
    if (data[SEQ_W+TAG_W+:LEN_W] !== want.len) begin
      report_mismatch("out_len", 32'(data[SEQ_W+TAG_W+:LEN_W]), 32'(want.len));
    end
    if (last !== want.last) begin
      report_mismatch("last", 32'(last), 32'(want.last));
    end
  endtask

  // Both channels are sampled at the rising edge where the handshake happens.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_seq  = 32'd1;
      head_slot = '0;
      for (int i = 0; i < SLOTS; i++) begin
        held[i]     = 1'b0;
        held_tag[i] = '0;
        held_len[i] = '0;
      end
      owed_words.delete();
      err_count = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_word(out_data_i, out_user_i, out_last_i);
      end
      if (in_valid_i && in_ready_i) begin
        resequence_packet(in_data_i[SEQ_W-1:0], in_data_i[SEQ_W+:TAG_W],
                          in_data_i[SEQ_W+TAG_W+:LEN_W], in_user_i);
      end
      errors_o  <= err_count;
      pending_o <= owed_words.size();
    end
  end

endmodule

[sim/tb_packet_resequencer_core.sv]
// ----------------------------------------------------------------------------
// tb_packet_resequencer_core: stream test of the packet resequencer
// Sends a short directed run over the drop, ack, duplicate, old and window
// edge cases, then bursts of packets in shuffled order with bad, oversize,
// stray and repeated packets mixed in. Both sides stall at random, and once
// the result side holds off long enough to back the block up. The checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_packet_resequencer_core;

  localparam int unsigned SLOTS   = prs_pkg::WINDOW_DEF;
  localparam int unsigned SEQ_W   = prs_pkg::SEQ_W;
  localparam int unsigned TAG_W   = prs_pkg::TAG_W;
  localparam int unsigned LEN_W   = prs_pkg::LEN_W;
  localparam int unsigned TDATA_W = prs_pkg::TDATA_W;

  logic               clk;
  logic               rst_n;
  logic               s_valid;
  logic               s_ready;
  logic [TDATA_W-1:0] s_data;   // seq, payload_tag, payload_len
  logic               s_user;   // crc_ok
  logic               m_valid;
  logic               m_ready;
  logic [TDATA_W-1:0] m_data;   // out_seq, out_tag, out_len
  logic               m_user;   // kind
  logic               m_last;   // last
  int                 errors;
  int                 pending;

  int                 words_in;
  int                 in_order_sent;
  bit                 quiet;

  packet_resequencer_core uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  prs_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (s_valid),
    .in_ready_i  (s_ready),
    .in_data_i   (s_data),
    .in_user_i   (s_user),
    .out_valid_i (m_valid),
    .out_ready_i (m_ready),
    .out_data_i  (m_data),
    .out_user_i  (m_user),
    .out_last_i  (m_last),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // Clock.
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Length of an idle gap: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Offers one packet word after a random gap and waits until it is taken.
  task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic [TAG_W-1:0] tag,
                             input logic [LEN_W-1:0] len, input logic crc_ok);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {{prs_pkg::PAD_W{1'b0}}, len, tag, seq};
    s_user  <= crc_ok;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    words_in++;
  endtask

  // Sends one stray packet near the current burst: bad CRC, oversize,
  // ahead of the window, behind it, or an early copy from the burst.
  task automatic send_noise(input logic [SEQ_W-1:0] base, input int n);
    logic [SEQ_W-1:0] seq;
    case ($urandom_range(0, 4))
      0: begin
        seq = $urandom_range(0, 1) ? $urandom : base + $urandom_range(0, n - 1);
        send_packet(seq, 16'($urandom), 11'($urandom_range(0, 2047)), 1'b0);
      end
      1: send_packet(base + $urandom_range(0, n - 1), 16'($urandom),
                     11'($urandom_range(1025, 2047)), 1'b1);
      2: send_packet(base + 64 + $urandom_range(0, 32'h7FFF_0000), 16'($urandom),
                     11'($urandom_range(0, 1024)), 1'b1);
      3: send_packet(base - 1 - $urandom_range(0, 32'h7FFF_FF00), 16'($urandom),
                     11'($urandom_range(0, 1024)), 1'b1);
      default: send_packet(base + $urandom_range(0, n - 1), 16'($urandom),
                           11'($urandom_range(0, 1024)), 1'b1);
    endcase
  endtask

  // Sends sequence numbers base .. base+n-1 in ascending, descending or
  // shuffled order, with stray packets mixed in.
  task automatic send_burst(input logic [SEQ_W-1:0] base, input int n, input int order);
    logic [SEQ_W-1:0] seqs[SLOTS];
    logic [SEQ_W-1:0] tmp;
    int               j;
    for (int i = 0; i < n; i++) begin
      seqs[i] = (order == 1) ? base + n - 1 - i : base + i;
    end
    if (order == 2) begin
      for (int i = n - 1; i > 0; i--) begin
        j       = $urandom_range(0, i);
        tmp     = seqs[i];
        seqs[i] = seqs[j];
        seqs[j] = tmp;
      end
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 15) begin
        send_noise(base, n);
      end
      send_packet(seqs[i], 16'($urandom), 11'($urandom_range(0, 1024)), 1'b1);
      in_order_sent++;
    end
  endtask

  // Packet side: reset, directed cases, random bursts, then the verdict.
  initial begin
    logic [SEQ_W-1:0] base;
    int               n;
    int               r;
    rst_n         = 1'b0;
    s_valid       = 1'b0;
    s_data        = '0;
    s_user        = 1'b0;
    words_in      = 0;
    in_order_sent = 0;
    quiet         = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Drops: bad CRC, then lengths just over the limit and at the top.
    send_packet(32'd1, 16'hFFFF, 11'd1024, 1'b0);
    send_packet(32'd1, 16'h0000, 11'd1025, 1'b1);
    send_packet(32'd1, 16'h0000, 11'd2047, 1'b1);
    // Stored ahead of the head, then a duplicate that must not replace it.
    send_packet(32'd2, 16'hAAAA, 11'd0, 1'b1);
    send_packet(32'd2, 16'h5555, 11'd7, 1'b1);
    // Last slot of the window, and the first one past it.
    send_packet(32'd32, 16'h1234, 11'd1024, 1'b1);
    send_packet(32'd33, 16'h4321, 11'd5, 1'b1);
    // Farthest ahead, then the nearest number that counts as old.
    send_packet(32'h8000_0000, 16'h0F0F, 11'd9, 1'b1);
    send_packet(32'h8000_0001, 16'hF0F0, 11'd9, 1'b1);
    // Old numbers across the wrap point.
    send_packet(32'h0000_0000, 16'h00FF, 11'd3, 1'b1);
    send_packet(32'hFFFF_FFFF, 16'hFF00, 11'd3, 1'b1);
    // Expected number arrives and releases the run 1, 2.
    send_packet(32'd1, 16'hFFFF, 11'd1024, 1'b1);
    send_packet(32'd1, 16'h0001, 11'd1, 1'b1);
    send_packet(32'd3, 16'h8001, 11'd1023, 1'b1);
    send_packet(32'h7FFF_FFFF, 16'h7FFE, 11'd512, 1'b1);

    // A full window in reverse order: one packet releases every slot.
    base = 32'd4;
    send_burst(base, SLOTS, 1);
    base = base + SLOTS;

    // Random bursts, mostly small.
    while (in_order_sent < 180) begin
      r     = $urandom_range(0, 7);
      n     = (r == 0) ? $urandom_range(9, SLOTS) : $urandom_range(1, 8);
      quiet = ($urandom_range(0, 4) == 0);
      r     = $urandom_range(0, 7);
      send_burst(base, n, (r < 2) ? 0 : (r == 2) ? 1 : 2);
      base = base + n;
    end
    s_valid <= 1'b0;

    // Drain: wait for every owed word, then let the block settle.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("packet_resequencer_core test passed");
    end else begin
      $display("packet_resequencer_core test failed");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off once the traffic is going.
  initial begin
    int stall;
    int run;
    bit hold_done;
    m_ready   = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (!hold_done && words_in >= 60) begin
        m_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
      end
      stall = pick_gap();
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 8);
      repeat (run) @(posedge clk);
    end
  end

  // Watchdog.
  initial begin
    #12000000;
    $display("packet_resequencer_core test failed");
    $finish;
  end

endmodule
